// ===== hdl/tlt_pkg.sv =====
// shared constants and types for the transaction lock table
package tlt_pkg;

    // fixed field widths of the request and result
    localparam int TLT_STAGE_W   = 4;
    localparam int TLT_SLOT_W    = 2;
    localparam int TLT_INDEX_W   = 16;
    localparam int TLT_TXN_W     = 32;
    localparam int TLT_STATUS_W  = 2;

    // default sizing
    localparam int TLT_INDEX_BITS   = 16;
    localparam int TLT_LOCK_ENTRIES = 64;

    typedef logic [TLT_STATUS_W-1:0] tlt_status_t;

    localparam tlt_status_t TLT_ST_OK      = 2'd0;
    localparam tlt_status_t TLT_ST_BLOCKED = 2'd1;
    localparam tlt_status_t TLT_ST_FULL    = 2'd2;

    typedef struct packed {
        tlt_status_t status;
        logic        released;
    } tlt_result_t;

endpackage

// ===== hdl/txn_lock_table.sv =====
// top level of the transaction lock table
//
// a request is taken at a rising edge with start high and busy low; busy
// stays low, so a request may be issued in every cycle
// command 0 checks a location: blocked if another transaction owns it,
// and a release of the caller's own lock when last_pass is set
// command 1 acquires a lock: blocked if the location is held, table full
// if no entry is free, otherwise the lowest free entry is taken
// the location key is {stage, reg_slot, low KIDX_W bits of entry_index}
// path: the request is registered, matched against every entry in
// parallel, and the result is registered; done is registered beside it and is
// high for the cycle in which that registered result shows
// throughput: one request per cycle; the table updates on the edge the
// result is registered, so a following request already sees its effect
// reset: rst_n clears every valid bit, so the table starts empty; key and
// owner storage is only read behind its valid bit
// stalls: none, the receiver cannot stall and each result shows for one cycle
module txn_lock_table #(
    parameter int INDEX_BITS   = tlt_pkg::TLT_INDEX_BITS,
    parameter int LOCK_ENTRIES = tlt_pkg::TLT_LOCK_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           command,
    input  logic [tlt_pkg::TLT_STAGE_W-1:0]  stage,
    input  logic [tlt_pkg::TLT_SLOT_W-1:0]   reg_slot,
    input  logic [tlt_pkg::TLT_INDEX_W-1:0]  entry_index,
    input  logic [tlt_pkg::TLT_TXN_W-1:0]    txn_id,
    input  logic                           last_pass,
    output logic                           done,
    output logic [tlt_pkg::TLT_STATUS_W-1:0] status,
    output logic                           released
);
    import tlt_pkg::*;

    // index bits kept in the key: the port carries at most TLT_INDEX_W bits
    localparam int KIDX_W = (INDEX_BITS < TLT_INDEX_W) ? INDEX_BITS : TLT_INDEX_W;
    localparam int KEY_W  = TLT_STAGE_W + TLT_SLOT_W + KIDX_W;

    // request register
    logic                 req_vld_reg;
    logic                 cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TLT_TXN_W-1:0] txn_reg;
    logic                 last_reg;
    logic                 accept;

    // result register
    logic        done_reg;
    tlt_result_t res_reg;
    tlt_result_t res_next;

    // entry match and allocation
    logic [LOCK_ENTRIES-1:0] valid_vec;
    logic [LOCK_ENTRIES-1:0] hit_vec;
    logic [LOCK_ENTRIES-1:0] own_vec;
    logic [LOCK_ENTRIES-1:0] grant_vec;
    logic [LOCK_ENTRIES-1:0] alloc_vec;
    logic [LOCK_ENTRIES-1:0] rel_vec;
    logic                    any_free;
    logic                    any_hit;
    logic                    own_hit;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            req_vld_reg <= accept;
            done_reg    <= req_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            key_reg  <= {stage, reg_slot, entry_index[KIDX_W-1:0]};
            txn_reg  <= txn_id;
            last_reg <= last_pass;
        end
        res_reg <= res_next;
    end

    tlt_cam #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .KEY_W        (KEY_W)
    ) u_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .txn       (txn_reg),
        .alloc_vec (alloc_vec),
        .rel_vec   (rel_vec),
        .valid_vec (valid_vec),
        .hit_vec   (hit_vec),
        .own_vec   (own_vec)
    );

    tlt_alloc #(
        .LOCK_ENTRIES (LOCK_ENTRIES)
    ) u_alloc (
        .valid_vec (valid_vec),
        .grant_vec (grant_vec),
        .any_free  (any_free)
    );

    // keys among valid entries are unique, so at most one hit
    assign any_hit = |hit_vec;
    assign own_hit = |(hit_vec & own_vec);

    always_comb
    begin
        res_next.status   = TLT_ST_OK;
        res_next.released = 1'b0;
        alloc_vec         = '0;
        rel_vec           = '0;
        if (!cmd_reg)
        begin
            // check of a touched location
            if (any_hit)
            begin
                if (own_hit)
                begin
                    if (last_reg)
                    begin
                        rel_vec           = req_vld_reg ? hit_vec : '0;
                        res_next.released = 1'b1;
                    end
                end
                else
                begin
                    res_next.status = TLT_ST_BLOCKED;
                end
            end
        end
        else
        begin
            // acquire, a held location blocks even for its own owner
            if (any_hit)
            begin
                res_next.status = TLT_ST_BLOCKED;
            end
            else if (!any_free)
            begin
                res_next.status = TLT_ST_FULL;
            end
            else
            begin
                alloc_vec = req_vld_reg ? grant_vec : '0;
            end
        end
    end

    assign done     = done_reg;
    assign status   = res_reg.status;
    assign released = res_reg.released;

endmodule

// ===== hdl/tlt_cam.sv =====
// lock entry store with a parallel key match and owner compare per entry
module tlt_cam #(
    parameter int LOCK_ENTRIES = tlt_pkg::TLT_LOCK_ENTRIES,
    parameter int KEY_W        = tlt_pkg::TLT_STAGE_W + tlt_pkg::TLT_SLOT_W
                                 + tlt_pkg::TLT_INDEX_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [KEY_W-1:0]            key,
    input  logic [tlt_pkg::TLT_TXN_W-1:0] txn,
    input  logic [LOCK_ENTRIES-1:0]     alloc_vec,
    input  logic [LOCK_ENTRIES-1:0]     rel_vec,
    output logic [LOCK_ENTRIES-1:0]     valid_vec,
    output logic [LOCK_ENTRIES-1:0]     hit_vec,
    output logic [LOCK_ENTRIES-1:0]     own_vec
);
    import tlt_pkg::*;

    logic [LOCK_ENTRIES-1:0] valid_reg;
    logic [LOCK_ENTRIES-1:0] valid_next;
    logic [KEY_W-1:0]        key_reg   [LOCK_ENTRIES];
    logic [TLT_TXN_W-1:0]    owner_reg [LOCK_ENTRIES];

    // a new lock sets its bit, a release clears it
    assign valid_next = (valid_reg & ~rel_vec) | alloc_vec;
    assign valid_vec  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < LOCK_ENTRIES; e++)
        begin
            if (alloc_vec[e])
            begin
                key_reg[e]   <= key;
                owner_reg[e] <= txn;
            end
        end
    end

    always_comb
    begin
        for (int e = 0; e < LOCK_ENTRIES; e++)
        begin
            hit_vec[e] = valid_reg[e] && (key_reg[e] == key);
            own_vec[e] = (owner_reg[e] == txn);
        end
    end

endmodule

// ===== hdl/tlt_alloc.sv =====
// picks the lowest free entry as a one-hot grant
module tlt_alloc #(
    parameter int LOCK_ENTRIES = tlt_pkg::TLT_LOCK_ENTRIES
) (
    input  logic [LOCK_ENTRIES-1:0] valid_vec,
    output logic [LOCK_ENTRIES-1:0] grant_vec,
    output logic                    any_free
);
    import tlt_pkg::*;

    logic [LOCK_ENTRIES-1:0] free_vec;

    assign free_vec  = ~valid_vec;
    // isolate lowest set bit
    assign grant_vec = free_vec & (~free_vec + {{(LOCK_ENTRIES-1){1'b0}}, 1'b1});
    assign any_free  = |free_vec;

endmodule
